[rtl/tvsg_pkg.sv]
// ----------------------------------------------------------------------------
// tvsg_pkg
// types, register map and constant tables of the three voice sound generator
// ----------------------------------------------------------------------------
package tvsg_pkg;

    localparam int NUM_CH      = 3;
    localparam int NUM_REGS    = 13;
    localparam int LEVEL_W     = 4;
    localparam int SAMPLE_W    = 15;
    localparam int TONE_CNT_W  = 13;
    localparam int ENV_CNT_W   = 17;
    localparam int ENV_POS_W   = 6;
    localparam int NOISE_CNT_W = 6;
    localparam int SEED_W      = 32;

    // request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // register map
    localparam logic [3:0] REG_TONE_A_LO = 4'd0;
    localparam logic [3:0] REG_NOISE     = 4'd6;
    localparam logic [3:0] REG_MIXER     = 4'd7;
    localparam logic [3:0] REG_VOL_A     = 4'd8;
    localparam logic [3:0] REG_ENV_LO    = 4'd11;
    localparam logic [3:0] REG_ENV_HI    = 4'd12;
    localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

    localparam logic [7:0]        SHAPE_IGNORE = 8'hff;
    localparam logic [SEED_W-1:0] SEED_INIT    = 32'h12345678;
    localparam logic [ENV_POS_W-1:0] ENV_LOOP_POS = 6'd32;

    localparam int MIX_SIDE_WEIGHT   = 687;
    localparam int MIX_CENTER_WEIGHT = 313;
    localparam int MIX_DIV           = 2000;

    typedef struct packed {
        logic       req_type;
        logic [3:0] reg_index;
        logic [7:0] reg_value;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]  level_a;
        logic [LEVEL_W-1:0]  level_b;
        logic [LEVEL_W-1:0]  level_c;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
    } out_item_t;

    localparam int unsigned VOL_TABLE [16] = '{
        0, 231, 695, 1158, 2084, 2779, 4168, 6716,
        8105, 13200, 18294, 24315, 32189, 40757, 52799, 65535
    };

    localparam logic [3:0] NOISE_MAP [5][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd0, 4'd0, 4'd2, 4'd2, 4'd4, 4'd4, 4'd6, 4'd6,
          4'd8, 4'd8, 4'd10, 4'd10, 4'd12, 4'd12, 4'd14, 4'd15},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd7, 4'd7, 4'd7, 4'd8,
          4'd8, 4'd8, 4'd9, 4'd9, 4'd9, 4'd15, 4'd15, 4'd15},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd8, 4'd8,
          4'd8, 4'd8, 4'd8, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
        '{4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd8, 4'd8,
          4'd8, 4'd8, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15}
    };

    typedef logic [SAMPLE_W-1:0] mix_table_t [256];

    // weighted side/center mix, indexed by {side level, center level}
    function automatic mix_table_t build_mix_table();
        mix_table_t  t;
        int unsigned acc;
        for (int a = 0; a < 16; a++) begin
            for (int b = 0; b < 16; b++) begin
                acc = MIX_SIDE_WEIGHT * VOL_TABLE[a] + MIX_CENTER_WEIGHT * VOL_TABLE[b];
                t[a * 16 + b] = SAMPLE_W'(acc / MIX_DIV);
            end
        end
        return t;
    endfunction

    localparam mix_table_t MIX_TABLE = build_mix_table();

endpackage

[rtl/three_voice_sound_generator.sv]
// ----------------------------------------------------------------------------
// three_voice_sound_generator
// Three tone channels, a noise source and a 64-step envelope behind fourteen
// byte registers. A write transfer (req_type 0) loads a register and gives no
// result; a tick transfer (req_type 1) advances the generator by one step and
// gives one result: the three 4-bit channel levels and a 15-bit left/right
// pair mixed from a 16-bit volume curve. One transfer is taken every clock
// cycle while input is not stalled, and its result shows in the output register
// in the next cycle; input stalls only while that register holds a result that m_ready has not taken.
// ----------------------------------------------------------------------------
module three_voice_sound_generator
    import tvsg_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_payload
);

    logic [7:0]             sound_regs_reg  [NUM_REGS];
    logic [7:0]             sound_regs_next [NUM_REGS];
    logic [TONE_CNT_W-1:0]  tone_count_reg  [NUM_CH];
    logic [TONE_CNT_W-1:0]  tone_count_next [NUM_CH];
    logic [NUM_CH-1:0]      tone_phase_reg, tone_phase_next;
    logic [ENV_CNT_W-1:0]   env_count_reg, env_count_next;
    logic [ENV_POS_W-1:0]   env_pos_reg, env_pos_next;
    logic [3:0]             env_shape_reg, env_shape_next;
    logic [NOISE_CNT_W-1:0] noise_count_reg, noise_count_next;
    logic [SEED_W-1:0]      noise_seed_reg, noise_seed_next;
    logic [3:0]             noise_level_reg, noise_level_next;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_payload_reg, m_payload_next;

    logic                   accept;
    logic [7:0]             mixer;
    logic [4:0]             noise_val;
    logic [11:0]            tone_per;
    logic [TONE_CNT_W-1:0]  tone_inc;
    logic [ENV_CNT_W-1:0]   env_per;
    logic [ENV_CNT_W-1:0]   env_inc;
    logic [ENV_POS_W-1:0]   env_pos_tick;
    logic [3:0]             env_now;
    logic                   noise_on;
    logic [NOISE_CNT_W-1:0] noise_inc;
    logic [SEED_W-1:0]      seed_asr;
    logic [SEED_W-1:0]      seed_step;
    logic [2:0]             noise_row;
    logic [7:0]             vol_reg;
    logic [LEVEL_W-1:0]     lvl [NUM_CH];

    function automatic logic [3:0] env_level(logic [3:0] shape, logic [ENV_POS_W-1:0] pos);
        logic [1:0] k;
        logic [3:0] s;
        logic       att;
        logic [3:0] lvl_out;
        k   = pos[5:4];
        s   = pos[3:0];
        att = shape[2];
        if (k == 2'd0) begin
            lvl_out = att ? s : 4'd15 - s;
        end else if (!shape[3]) begin
            lvl_out = 4'd0;
        end else if (shape[0]) begin
            lvl_out = {4{att ^ shape[1]}};
        end else begin
            att     = att ^ (shape[1] & k[0]);
            lvl_out = att ? s : 4'd15 - s;
        end
        return lvl_out;
    endfunction

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign mixer     = sound_regs_reg[REG_MIXER];
    assign noise_val = sound_regs_reg[REG_NOISE][4:0];
    assign noise_on  = (mixer[5:3] != 3'b111);

    always_comb begin
        for (int r = 0; r < NUM_REGS; r++) begin
            sound_regs_next[r] = sound_regs_reg[r];
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            tone_count_next[ch] = tone_count_reg[ch];
        end
        tone_phase_next  = tone_phase_reg;
        env_count_next   = env_count_reg;
        env_pos_next     = env_pos_reg;
        env_shape_next   = env_shape_reg;
        noise_count_next = noise_count_reg;
        noise_seed_next  = noise_seed_reg;
        noise_level_next = noise_level_reg;
        m_payload_next   = m_payload_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        tone_per = '0;
        tone_inc = '0;
        vol_reg  = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            lvl[ch] = '0;
        end

        // tick datapath
        env_per = {sound_regs_reg[REG_ENV_HI], sound_regs_reg[REG_ENV_LO], 1'b0};
        env_inc = env_count_reg + 1'b1;
        env_pos_tick = env_pos_reg;
        if (env_inc >= env_per) begin
            env_pos_tick = (env_pos_reg == '1) ? ENV_LOOP_POS : env_pos_reg + 1'b1;
        end
        env_now   = env_level(env_shape_reg, env_pos_tick);
        noise_inc = noise_count_reg + 1'b1;
        seed_asr  = SEED_W'($signed(noise_seed_reg) >>> 7);
        seed_step = noise_seed_reg ^ (seed_asr ^ (noise_seed_reg << 3));
        if (noise_val <= 5'd1) begin
            noise_row = 3'd0;
        end else if (noise_val >= 5'd5) begin
            noise_row = 3'd4;
        end else begin
            noise_row = 3'(noise_val - 5'd1);
        end

        if (accept) begin
            unique case (s_payload.req_type)
                REQ_WRITE: begin
                    if (s_payload.reg_index == REG_ENV_SHAPE) begin
                        if (s_payload.reg_value != SHAPE_IGNORE) begin
                            env_shape_next = s_payload.reg_value[3:0];
                            env_count_next = '0;
                            env_pos_next   = '0;
                        end
                    end else if (s_payload.reg_index < REG_ENV_SHAPE) begin
                        sound_regs_next[s_payload.reg_index] = s_payload.reg_value;
                    end
                end
                REQ_TICK: begin
                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        tone_per = {sound_regs_reg[2 * ch + 1][3:0], sound_regs_reg[2 * ch]};
                        tone_inc = tone_count_reg[ch] + 1'b1;
                        if (tone_inc >= {1'b0, tone_per}) begin
                            tone_phase_next[ch] = !tone_phase_reg[ch];
                            tone_count_next[ch] = '0;
                        end else begin
                            tone_count_next[ch] = tone_inc;
                        end
                    end
                    env_count_next = (env_inc >= env_per) ? '0 : env_inc;
                    env_pos_next   = env_pos_tick;

                    for (int ch = 0; ch < NUM_CH; ch++) begin
                        vol_reg = sound_regs_reg[int'(REG_VOL_A) + ch];
                        lvl[ch] = vol_reg[4] ? env_now : vol_reg[3:0];
                        if (!mixer[ch] && !tone_phase_next[ch]) begin
                            lvl[ch] = '0;
                        end
                    end

                    if (noise_on) begin
                        if (noise_inc >= {noise_val, 1'b0}) begin
                            noise_count_next = '0;
                            noise_seed_next  = seed_step;
                            noise_level_next = NOISE_MAP[noise_row][seed_step[3:0]];
                        end else begin
                            noise_count_next = noise_inc;
                        end
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            if (!mixer[3 + ch] && noise_level_next < lvl[ch]) begin
                                lvl[ch] = noise_level_next;
                            end
                        end
                    end

                    m_valid_next                = 1'b1;
                    m_payload_next.level_a      = lvl[0];
                    m_payload_next.level_b      = lvl[1];
                    m_payload_next.level_c      = lvl[2];
                    m_payload_next.left_sample  = MIX_TABLE[{lvl[0], lvl[1]}];
                    m_payload_next.right_sample = MIX_TABLE[{lvl[2], lvl[1]}];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < NUM_REGS; r++) begin
                sound_regs_reg[r] <= '0;
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                tone_count_reg[ch] <= '0;
            end
            tone_phase_reg  <= '1;
            env_count_reg   <= '0;
            env_pos_reg     <= '0;
            env_shape_reg   <= '0;
            noise_count_reg <= '0;
            noise_seed_reg  <= SEED_INIT;
            noise_level_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            for (int r = 0; r < NUM_REGS; r++) begin
                sound_regs_reg[r] <= sound_regs_next[r];
            end
            for (int ch = 0; ch < NUM_CH; ch++) begin
                tone_count_reg[ch] <= tone_count_next[ch];
            end
            tone_phase_reg  <= tone_phase_next;
            env_count_reg   <= env_count_next;
            env_pos_reg     <= env_pos_next;
            env_shape_reg   <= env_shape_next;
            noise_count_reg <= noise_count_next;
            noise_seed_reg  <= noise_seed_next;
            noise_level_reg <= noise_level_next;
            m_valid_reg     <= m_valid_next;
        end
        m_payload_reg <= m_payload_next;
    end

endmodule

[rtl/tvsg_checker.sv]
// ----------------------------------------------------------------------------
// tvsg_checker
// port-level checks of the three voice sound generator
// ----------------------------------------------------------------------------
module tvsg_checker
    import tvsg_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_payload,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_payload
);

    // a held result stays until its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload))
        else $error("result dropped or changed while stalled");

    // input is never stalled while the output register is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

    // every tick transfer gives a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.req_type == REQ_TICK |=> m_valid)
        else $error("tick transfer gave no result");

    // a write transfer never creates a result
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_payload.req_type == REQ_WRITE && (!m_valid || m_ready)
        |=> !m_valid)
        else $error("write transfer gave a result");

    // silent side and center channels give a silent sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_payload.level_a == '0 && m_payload.level_b == '0
        |-> m_payload.left_sample == '0)
        else $error("left sample not silent");

endmodule

bind three_voice_sound_generator tvsg_checker u_tvsg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_payload (s_payload),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_payload (m_payload)
);
